FILE: rtl/core/d2q9e_pkg.sv
package d2q9e_pkg;

  localparam int DW     = 24;          // Q8.16 field width
  localparam int NDIR   = 9;           // D2Q9 directions
  localparam int SUMW   = DW + 4;      // sum of nine values
  localparam int MW     = DW + 3;      // first moment, six terms
  localparam int QDEPTH = 4;           // front to back queue
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);
  localparam int CFGW   = 3;           // config index width

  typedef logic signed [DW-1:0] data_t;

  localparam data_t DATA_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam data_t DATA_MIN = {1'b1, {(DW-1){1'b0}}};

  // register indexes of the config port
  typedef logic [CFGW-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_W_REST  = 3'd0;
  localparam cfg_idx_t REG_W_AXIS  = 3'd1;
  localparam cfg_idx_t REG_W_DIAG  = 3'd2;
  localparam cfg_idx_t REG_C_LIN   = 3'd3;
  localparam cfg_idx_t REG_C_QUAD  = 3'd4;
  localparam cfg_idx_t REG_C_SPEED = 3'd5;

  typedef struct packed {
    logic [DW-1:0] w_rest;
    logic [DW-1:0] w_axis;
    logic [DW-1:0] w_diag;
    logic [DW-1:0] c_lin;
    logic [DW-1:0] c_quad;
    logic [DW-1:0] c_speed;
  } coef_t;

  // classified node handed from front to back
  typedef struct packed {
    data_t                rho;
    logic signed [MW-1:0] mx;
    logic signed [MW-1:0] my;
    logic                 div_en;
  } node_t;

  function automatic data_t sat_data(input logic signed [63:0] v);
    data_t r;
    if (v > 64'(DATA_MAX)) begin
      r = DATA_MAX;
    end else if (v < 64'(DATA_MIN)) begin
      r = DATA_MIN;
    end else begin
      r = v[DW-1:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/d2q9e_front.sv
module d2q9e_front (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  input  logic [d2q9e_pkg::NDIR*d2q9e_pkg::DW-1:0] in_tdata,
  input  logic                                     in_tuser,
  input  logic                                     q_full,
  output logic                                     q_push,
  output d2q9e_pkg::node_t                         q_item
);
  import d2q9e_pkg::*;

  logic [NDIR*DW-1:0]     dist_r;
  logic                   fluid_r;
  logic                   valid_r, valid_nxt;
  data_t                  f [NDIR];
  logic signed [SUMW-1:0] sum_c;
  data_t                  rho_c;

  assign in_tready = !valid_r || !q_full;
  assign q_push    = valid_r && !q_full;
  assign valid_nxt = in_tready ? in_tvalid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      dist_r  <= in_tdata;
      fluid_r <= in_tuser;
    end
  end

  always_comb begin
    sum_c = '0;
    for (int i = 0; i < NDIR; i++) begin
      f[i]  = $signed(dist_r[i*DW +: DW]);
      sum_c = sum_c + SUMW'(f[i]);
    end
  end

  assign rho_c = sat_data(64'(sum_c));

  // unit vectors: e n w s ne nw sw se
  always_comb begin
    q_item.rho    = rho_c;
    q_item.mx     = MW'(f[1]) + MW'(f[5]) + MW'(f[8]) - MW'(f[3]) - MW'(f[6]) - MW'(f[7]);
    q_item.my     = MW'(f[2]) + MW'(f[5]) + MW'(f[6]) - MW'(f[4]) - MW'(f[7]) - MW'(f[8]);
    q_item.div_en = fluid_r && (rho_c > 0);
  end

endmodule

FILE: rtl/core/d2q9e_queue.sv
module d2q9e_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  d2q9e_pkg::node_t wr_item,
  output logic             full,
  input  logic             pop,
  output logic             rd_valid,
  output d2q9e_pkg::node_t rd_item
);
  import d2q9e_pkg::*;

  node_t            mem [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]   cnt_r, cnt_nxt;

  assign full     = (cnt_r == QCW'(QDEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_item  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCW'(push) - QCW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_item;
    end
  end

endmodule

FILE: rtl/core/d2q9e_back.sv
module d2q9e_back (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         q_valid,
  input  d2q9e_pkg::node_t                             q_item,
  output logic                                         q_pop,
  input  d2q9e_pkg::coef_t                             coef,
  output logic                                         out_tvalid,
  input  logic                                         out_tready,
  output logic [(d2q9e_pkg::NDIR+3)*d2q9e_pkg::DW-1:0] out_tdata
);
  import d2q9e_pkg::*;

  localparam int QBITS  = DW - 1;          // quotient bits below saturation
  localparam int DIV_ST = QBITS + 1;       // setup stage plus one bit a stage
  localparam int NPIPE  = DIV_ST + 6;
  localparam int NUMW   = MW + 16;
  localparam int HIW    = NUMW - QBITS;
  localparam int RTW    = 32;
  localparam int PW     = DW + 1;
  localparam int SQW    = 2 * DW + 1;
  localparam int LINW   = 2 * PW;
  localparam int LFW    = LINW - 16;
  localparam int QVW    = SQW - 16;
  localparam int SPL    = 17;
  localparam int SW     = QVW + 1;
  localparam int PBW    = DW + SPL;
  localparam int BQW    = PBW + SPL;
  localparam int BFW    = BQW - 16;
  localparam int CSW    = PBW + SPL + 1;
  localparam int CFW    = CSW - 16;
  localparam int BRW    = CFW + 3;
  localparam int OUTW   = (NDIR + 3) * DW;
  localparam int NSQ    = 4;
  localparam int NCLS   = 3;

  localparam logic [1:0] LIN_ZERO = 2'd0;
  localparam logic [1:0] LIN_POS  = 2'd1;
  localparam logic [1:0] LIN_NEG  = 2'd2;

  localparam int CLS_REST = 0;
  localparam int CLS_AXIS = 1;
  localparam int CLS_DIAG = 2;

  // projections: ux, uy, ux+uy, ux-uy
  localparam int         DIR_SQ  [NDIR] = '{0, 0, 1, 0, 1, 2, 3, 2, 3};
  localparam logic [1:0] DIR_SGN [NDIR] = '{LIN_ZERO, LIN_POS, LIN_POS, LIN_NEG, LIN_NEG,
                                            LIN_POS, LIN_NEG, LIN_NEG, LIN_POS};
  localparam int         DIR_CLS [NDIR] = '{CLS_REST, CLS_AXIS, CLS_AXIS, CLS_AXIS, CLS_AXIS,
                                            CLS_DIAG, CLS_DIAG, CLS_DIAG, CLS_DIAG};

  localparam logic signed [BRW-1:0] BR_HI  = {{(BRW-RTW+1){1'b0}}, {(RTW-1){1'b1}}};
  localparam logic signed [BRW-1:0] BR_LO  = {{(BRW-RTW+1){1'b1}}, {(RTW-1){1'b0}}};
  localparam logic signed [BRW-1:0] BR_ONE = BRW'(65536);

  typedef struct packed {
    data_t            rho;
    logic             en;
    logic [DW-1:0]    remx;
    logic [DW-1:0]    remy;
    logic [QBITS-1:0] qx;
    logic [QBITS-1:0] qy;
    logic [QBITS-1:0] lox;
    logic [QBITS-1:0] loy;
    logic             ovx;
    logic             ovy;
    logic             negx;
    logic             negy;
  } div_st_t;

  typedef struct packed {
    data_t rho;
    data_t ux;
    data_t uy;
  } side_t;

  logic                     adv;
  logic [NPIPE-1:0]         pv_r;
  logic                     out_valid_r;
  div_st_t                  dv_r   [DIV_ST];
  div_st_t                  dv_nxt [DIV_ST];
  side_t                    side_r [6];
  logic signed [RTW-1:0]    rt_r   [5][NCLS];
  logic [SQW-1:0]           sq_r   [NSQ];
  logic signed [LINW-1:0]   lin1_r [NSQ];
  logic signed [LINW-1:0]   lin2_r [NSQ];
  logic [PBW-1:0]           pbl_r  [NSQ];
  logic [PBW-1:0]           pbh_r  [NSQ];
  logic [PBW-1:0]           pcl_r, pch_r;
  logic [BFW-1:0]           bqf_r  [NSQ];
  logic [CFW-1:0]           csf_r;
  logic signed [LFW-1:0]    linp_r [NSQ];
  logic signed [LFW-1:0]    linn_r [NSQ];
  logic signed [RTW-1:0]    br_r   [NDIR];
  logic signed [2*RTW-1:0]  prod_r [NDIR];
  logic [OUTW-1:0]          tdata_r, tdata_nxt;

  data_t                    ux_c, uy_c;
  logic signed [RTW-1:0]    rt_c   [NCLS];
  logic signed [PW-1:0]     pj_c   [NSQ];
  logic [QVW-1:0]           qv_c   [NSQ];
  logic [SW-1:0]            s_c;
  logic [BFW-1:0]           bqf_c  [NSQ];
  logic [CFW-1:0]           csf_c;
  logic signed [LFW-1:0]    linp_c [NSQ];
  logic signed [LFW-1:0]    linn_c [NSQ];
  logic signed [RTW-1:0]    br_c   [NDIR];

  assign adv        = !out_valid_r || out_tready;
  assign q_pop      = adv && q_valid;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = tdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      pv_r        <= {pv_r[NPIPE-2:0], q_valid};
      out_valid_r <= pv_r[NPIPE-1];
    end
  end

  // divider: setup with overflow check, then one quotient bit a stage
  always_comb begin
    logic signed [NUMW-1:0] numx, numy;
    logic [NUMW-1:0]        magx, magy;
    logic [DW-1:0]          rho_u;
    logic [DW:0]            tx, ty, dvs;
    rho_u = q_item.rho;
    numx  = {q_item.mx, 16'b0};
    numy  = {q_item.my, 16'b0};
    magx  = q_item.mx[MW-1] ? -numx : numx;
    magy  = q_item.my[MW-1] ? -numy : numy;
    dv_nxt[0].rho  = q_item.rho;
    dv_nxt[0].en   = q_item.div_en;
    dv_nxt[0].negx = q_item.mx[MW-1];
    dv_nxt[0].negy = q_item.my[MW-1];
    dv_nxt[0].ovx  = DW'(magx[NUMW-1:QBITS]) >= rho_u;
    dv_nxt[0].ovy  = DW'(magy[NUMW-1:QBITS]) >= rho_u;
    dv_nxt[0].remx = DW'(magx[NUMW-1:QBITS]);
    dv_nxt[0].remy = DW'(magy[NUMW-1:QBITS]);
    dv_nxt[0].lox  = magx[QBITS-1:0];
    dv_nxt[0].loy  = magy[QBITS-1:0];
    dv_nxt[0].qx   = '0;
    dv_nxt[0].qy   = '0;
    for (int j = 1; j < DIV_ST; j++) begin
      dv_nxt[j] = dv_r[j-1];
      dvs = {1'b0, dv_r[j-1].rho};
      tx  = {dv_r[j-1].remx, dv_r[j-1].lox[QBITS-j]};
      ty  = {dv_r[j-1].remy, dv_r[j-1].loy[QBITS-j]};
      dv_nxt[j].qx[QBITS-j] = (tx >= dvs);
      dv_nxt[j].qy[QBITS-j] = (ty >= dvs);
      dv_nxt[j].remx = (tx >= dvs) ? DW'(tx - dvs) : DW'(tx);
      dv_nxt[j].remy = (ty >= dvs) ? DW'(ty - dvs) : DW'(ty);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < DIV_ST; j++) begin
        dv_r[j] <= dv_nxt[j];
      end
    end
  end

  // velocity and scaled weights
  always_comb begin
    div_st_t d;
    d = dv_r[DIV_ST-1];
    if (!d.en) begin
      ux_c = '0;
      uy_c = '0;
    end else begin
      if (d.ovx) begin
        ux_c = d.negx ? DATA_MIN : DATA_MAX;
      end else begin
        ux_c = d.negx ? -data_t'({1'b0, d.qx}) : data_t'({1'b0, d.qx});
      end
      if (d.ovy) begin
        uy_c = d.negy ? DATA_MIN : DATA_MAX;
      end else begin
        uy_c = d.negy ? -data_t'({1'b0, d.qy}) : data_t'({1'b0, d.qy});
      end
    end
  end

  always_comb begin
    logic signed [2*DW:0] pw [NCLS];
    pw[CLS_REST] = $signed({1'b0, coef.w_rest}) * dv_r[DIV_ST-1].rho;
    pw[CLS_AXIS] = $signed({1'b0, coef.w_axis}) * dv_r[DIV_ST-1].rho;
    pw[CLS_DIAG] = $signed({1'b0, coef.w_diag}) * dv_r[DIV_ST-1].rho;
    for (int k = 0; k < NCLS; k++) begin
      rt_c[k] = pw[k][16 +: RTW];
    end
  end

  always_comb begin
    pj_c[0] = PW'(side_r[0].ux);
    pj_c[1] = PW'(side_r[0].uy);
    pj_c[2] = PW'(side_r[0].ux) + PW'(side_r[0].uy);
    pj_c[3] = PW'(side_r[0].ux) - PW'(side_r[0].uy);
  end

  always_comb begin
    for (int k = 0; k < NSQ; k++) begin
      qv_c[k] = sq_r[k][SQW-1:16];
    end
    s_c = SW'(qv_c[0]) + SW'(qv_c[1]);
  end

  always_comb begin
    logic [BQW-1:0]        bq;
    logic [CSW-1:0]        cs;
    logic signed [LINW-1:0] ln;
    for (int k = 0; k < NSQ; k++) begin
      bq        = {pbh_r[k], {SPL{1'b0}}} + BQW'(pbl_r[k]);
      bqf_c[k]  = bq[BQW-1:16];
      ln        = -lin2_r[k];
      linp_c[k] = lin2_r[k][LINW-1:16];
      linn_c[k] = ln[LINW-1:16];
    end
    cs    = CSW'({pch_r, {SPL{1'b0}}}) + CSW'(pcl_r);
    csf_c = cs[CSW-1:16];
  end

  // bracket per direction, clamped to 32 bits
  always_comb begin
    logic signed [BRW-1:0] lt, bt, full;
    for (int i = 0; i < NDIR; i++) begin
      case (DIR_SGN[i])
        LIN_POS: begin
          lt = BRW'(linp_r[DIR_SQ[i]]);
          bt = $signed(BRW'(bqf_r[DIR_SQ[i]]));
        end
        LIN_NEG: begin
          lt = BRW'(linn_r[DIR_SQ[i]]);
          bt = $signed(BRW'(bqf_r[DIR_SQ[i]]));
        end
        default: begin
          lt = '0;
          bt = '0;
        end
      endcase
      full = BR_ONE + lt + bt - $signed(BRW'(csf_r));
      if (full > BR_HI) begin
        br_c[i] = BR_HI[RTW-1:0];
      end else if (full < BR_LO) begin
        br_c[i] = BR_LO[RTW-1:0];
      end else begin
        br_c[i] = full[RTW-1:0];
      end
    end
  end

  always_comb begin
    logic signed [2*RTW-1:0] sh;
    tdata_nxt            = '0;
    tdata_nxt[0 +: DW]   = side_r[5].rho;
    tdata_nxt[DW +: DW]  = side_r[5].ux;
    tdata_nxt[2*DW +: DW] = side_r[5].uy;
    for (int i = 0; i < NDIR; i++) begin
      sh = prod_r[i] >>> 16;
      tdata_nxt[(3+i)*DW +: DW] = sat_data(sh);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= '{rho: dv_r[DIV_ST-1].rho, ux: ux_c, uy: uy_c};
      for (int k = 0; k < NCLS; k++) begin
        rt_r[0][k] <= rt_c[k];
      end
      for (int st = 1; st < 6; st++) begin
        side_r[st] <= side_r[st-1];
      end
      for (int st = 1; st < 5; st++) begin
        for (int k = 0; k < NCLS; k++) begin
          rt_r[st][k] <= rt_r[st-1][k];
        end
      end
      for (int k = 0; k < NSQ; k++) begin
        sq_r[k]   <= SQW'(pj_c[k] * pj_c[k]);
        lin1_r[k] <= $signed({1'b0, coef.c_lin}) * pj_c[k];
        lin2_r[k] <= lin1_r[k];
        pbl_r[k]  <= coef.c_quad * qv_c[k][SPL-1:0];
        pbh_r[k]  <= PBW'(coef.c_quad * qv_c[k][QVW-1:SPL]);
        bqf_r[k]  <= bqf_c[k];
        linp_r[k] <= linp_c[k];
        linn_r[k] <= linn_c[k];
      end
      pcl_r <= coef.c_speed * s_c[SPL-1:0];
      pch_r <= coef.c_speed * s_c[SW-1:SPL];
      csf_r <= csf_c;
      for (int i = 0; i < NDIR; i++) begin
        br_r[i]   <= br_c[i];
        prod_r[i] <= rt_r[4][DIR_CLS[i]] * br_r[i];
      end
      tdata_r <= tdata_nxt;
    end
  end

endmodule

FILE: rtl/core/d2q9_macroscopic_equilibrium_core.sv
// D2Q9 lattice node core: takes one node per item (nine distributions in
// rest, e, n, w, s, ne, nw, sw, se order plus a fluid flag) and returns its
// density, x/y velocity and nine BGK equilibrium values, all signed Q8.16
// with saturation. Solid nodes and nodes with non-positive density get zero
// velocity. Weights and expansion coefficients sit in six config registers.
// The user must see that they are written while the core is idle; the core
// does not enforce it. The core takes one node per cycle unless its queue
// is full. Each node passes the moment front end, a four-entry queue, the
// 24-stage restoring divider (a setup stage, then one quotient bit per
// stage) for the velocities, a six-stage multiply pipeline for the
// equilibrium and an output register. The queue lets the input keep going
// for a few nodes while the result side is stalled.
module d2q9_macroscopic_equilibrium_core (
  input  logic                                         clk,
  input  logic                                         rst_n,
  // dist_rest .. dist_southeast, 24 bits each, from bit 0 up
  input  logic                                         in_tvalid,
  output logic                                         in_tready,
  input  logic [d2q9e_pkg::NDIR*d2q9e_pkg::DW-1:0]     in_tdata,
  // is_fluid
  input  logic                                         in_tuser,
  // density, vel_x, vel_y, eq_rest .. eq_southeast, 24 bits each, from bit 0 up
  output logic                                         out_tvalid,
  input  logic                                         out_tready,
  output logic [(d2q9e_pkg::NDIR+3)*d2q9e_pkg::DW-1:0] out_tdata,
  input  logic                                         cfg_valid,
  output logic                                         cfg_ready,
  input  logic [d2q9e_pkg::CFGW-1:0]                   cfg_index,
  input  logic [d2q9e_pkg::DW-1:0]                     cfg_data
);
  import d2q9e_pkg::*;

  coef_t coef_r;
  logic  q_full, q_push, q_valid, q_pop;
  node_t push_item, head_item;

  // config writes are always accepted and registered
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.w_rest  <= DW'(29127);     // about 4/9
      coef_r.w_axis  <= DW'(7282);      // about 1/9
      coef_r.w_diag  <= DW'(1820);      // about 1/36
      coef_r.c_lin   <= DW'(196608);    // 3.0
      coef_r.c_quad  <= DW'(294912);    // 4.5
      coef_r.c_speed <= DW'(98304);     // 1.5
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_W_REST:  coef_r.w_rest  <= cfg_data;
        REG_W_AXIS:  coef_r.w_axis  <= cfg_data;
        REG_W_DIAG:  coef_r.w_diag  <= cfg_data;
        REG_C_LIN:   coef_r.c_lin   <= cfg_data;
        REG_C_QUAD:  coef_r.c_quad  <= cfg_data;
        REG_C_SPEED: coef_r.c_speed <= cfg_data;
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // front: register the node, sum density and moments, classify
  d2q9e_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  // short queue decouples the two halves
  d2q9e_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_item  (push_item),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_item  (head_item)
  );

  // back: velocity divide, equilibrium, output register
  d2q9e_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (head_item),
    .q_pop      (q_pop),
    .coef       (coef_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
